@@ hw/rtl/wfncf_pkg.sv @@
// ----------------------------------------------------------------------------
// wfncf_pkg
// Shared types and constants of the waveform noise channel flagger.
// ----------------------------------------------------------------------------
package wfncf_pkg;

	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned CHANNEL_W = 14;
	localparam int unsigned Q124_W    = 16;
	localparam int unsigned CUT_W     = 13;
	localparam int unsigned ADDR_W    = 4;
	localparam int unsigned DATA_W    = 32;

	// ADC code flagged as a corrupted sample
	localparam logic [SAMPLE_W-1:0] BAD_CODE = 12'hBAD;

	// register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_SIGMA_CUT     = 2'd0,
		REG_BAD_CODE_CUT  = 2'd1,
		REG_PED_DISTANCE  = 2'd2,
		REG_AWAY_CUT      = 2'd3
	} reg_idx_t;

	localparam logic [Q124_W-1:0]   SIGMA_CUT_RST   = 16'd1600;
	localparam logic [CUT_W-1:0]    BAD_CODE_CUT_RST = 13'd5;
	localparam logic [SAMPLE_W-1:0] PED_DISTANCE_RST = 12'd100;
	localparam logic [CUT_W-1:0]    AWAY_CUT_RST    = 13'd100;

endpackage

@@ hw/rtl/waveform_noise_channel_flagger_unit.sv @@
// ----------------------------------------------------------------------------
// waveform_noise_channel_flagger_unit
// Per-channel noise checks on a stream of raw ADC samples, one verdict a wave.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one raw sample per transaction; the first
// sample of a waveform also carries channel_id, pedestal and sigma, marked by
// first_of_wave. last_of_wave closes the waveform and produces one verdict on
// the output channel (out_valid/out_ready); other samples produce nothing.
// A sample is registered on acceptance and evaluated in the next cycle; the
// verdict is loaded into the output register when the last sample leaves the
// input register, which waits while an earlier verdict is still held.
// Throughput: one sample per cycle, set by the single evaluation stage, which
// updates counters and result register together; a closing sample can stall.
// A held verdict does not block samples that produce no result; a second
// verdict waits in the input register and in_ready drops only then.
// Reset clears the counters, held channel and pedestal, sets the parity flag
// and loads the register defaults; pready is always high. Registers are to be
// written over the APB-style port only while the stream is idle (not enforced).
// ----------------------------------------------------------------------------
module waveform_noise_channel_flagger_unit #(
	parameter int unsigned MAX_SAMPLES = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wfncf_pkg::ADDR_W-1:0]        paddr,
	input  logic [wfncf_pkg::DATA_W-1:0]        pwdata,
	output logic [wfncf_pkg::DATA_W-1:0]        prdata,
	output logic                                pready,
	// sample stream
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wfncf_pkg::SAMPLE_W-1:0]      sample,
	input  logic [wfncf_pkg::CHANNEL_W-1:0]     channel_id,
	input  logic [wfncf_pkg::Q124_W-1:0]        pedestal,
	input  logic [wfncf_pkg::Q124_W-1:0]        sigma,
	input  logic                                first_of_wave,
	input  logic                                last_of_wave,
	// verdicts
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [wfncf_pkg::CHANNEL_W-1:0]     channel_out,
	output logic                                bad,
	output logic                                sigma_high,
	output logic                                bad_codes_high,
	output logic                                same_parity,
	output logic                                away_high
);

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned CMP_W = (CNT_W > wfncf_pkg::CUT_W) ? CNT_W : wfncf_pkg::CUT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

	// configuration registers
	logic [wfncf_pkg::Q124_W-1:0]   sigma_cut_q;
	logic [wfncf_pkg::CUT_W-1:0]    bad_code_cut_q;
	logic [wfncf_pkg::SAMPLE_W-1:0] ped_distance_q;
	logic [wfncf_pkg::CUT_W-1:0]    away_cut_q;

	logic                   cfg_wr;
	wfncf_pkg::reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = wfncf_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_cut_q    <= wfncf_pkg::SIGMA_CUT_RST;
			bad_code_cut_q <= wfncf_pkg::BAD_CODE_CUT_RST;
			ped_distance_q <= wfncf_pkg::PED_DISTANCE_RST;
			away_cut_q     <= wfncf_pkg::AWAY_CUT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				wfncf_pkg::REG_SIGMA_CUT:    sigma_cut_q    <= pwdata[wfncf_pkg::Q124_W-1:0];
				wfncf_pkg::REG_BAD_CODE_CUT: bad_code_cut_q <= pwdata[wfncf_pkg::CUT_W-1:0];
				wfncf_pkg::REG_PED_DISTANCE: ped_distance_q <= pwdata[wfncf_pkg::SAMPLE_W-1:0];
				wfncf_pkg::REG_AWAY_CUT:     away_cut_q     <= pwdata[wfncf_pkg::CUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			wfncf_pkg::REG_SIGMA_CUT:    prdata = wfncf_pkg::DATA_W'(sigma_cut_q);
			wfncf_pkg::REG_BAD_CODE_CUT: prdata = wfncf_pkg::DATA_W'(bad_code_cut_q);
			wfncf_pkg::REG_PED_DISTANCE: prdata = wfncf_pkg::DATA_W'(ped_distance_q);
			wfncf_pkg::REG_AWAY_CUT:     prdata = wfncf_pkg::DATA_W'(away_cut_q);
			default:                     prdata = '0;
		endcase
	end

	// input register
	logic                              valid_s1;
	logic [wfncf_pkg::SAMPLE_W-1:0]    sample_s1;
	logic [wfncf_pkg::CHANNEL_W-1:0]   channel_s1;
	logic [wfncf_pkg::Q124_W-1:0]      pedestal_s1;
	logic [wfncf_pkg::Q124_W-1:0]      sigma_s1;
	logic                              first_s1;
	logic                              last_s1;

	logic out_valid_q;
	logic advance_s1;

	// a sample without a verdict never waits for the output side
	assign advance_s1 = valid_s1 & (~last_s1 | ~out_valid_q | out_ready);
	assign in_ready   = ~valid_s1 | advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1   <= sample;
			channel_s1  <= channel_id;
			pedestal_s1 <= pedestal;
			sigma_s1    <= sigma;
			first_s1    <= first_of_wave;
			last_s1     <= last_of_wave;
		end
	end

	// per-waveform state
	logic                            first_parity_q;
	logic [CNT_W-1:0]                bad_cnt_q;
	logic [CNT_W-1:0]                away_cnt_q;
	logic                            parity_same_q;
	logic [wfncf_pkg::CHANNEL_W-1:0] held_channel_q;
	logic [wfncf_pkg::Q124_W-1:0]    held_pedestal_q;
	logic                            sigma_flag_q;

	logic                            fp_d;
	logic [CNT_W-1:0]                bad_base;
	logic [CNT_W-1:0]                away_base;
	logic                            par_base;
	logic [wfncf_pkg::CHANNEL_W-1:0] chan_d;
	logic [wfncf_pkg::Q124_W-1:0]    ped_d;
	logic                            sflag_d;
	logic [CNT_W-1:0]                bad_cnt_d;
	logic [CNT_W-1:0]                away_cnt_d;
	logic                            par_d;
	logic [wfncf_pkg::Q124_W-1:0]    s16;
	logic [wfncf_pkg::Q124_W-1:0]    ped_gap;
	logic [wfncf_pkg::Q124_W-1:0]    dist_lim;
	logic                            is_away;
	logic                            r_bad_codes;
	logic                            r_away;

	always_comb begin
		if (first_s1) begin
			fp_d      = sample_s1[0];
			bad_base  = '0;
			away_base = '0;
			par_base  = 1'b1;
			chan_d    = channel_s1;
			ped_d     = pedestal_s1;
			sflag_d   = sigma_s1 > sigma_cut_q;
		end else begin
			fp_d      = first_parity_q;
			bad_base  = bad_cnt_q;
			away_base = away_cnt_q;
			par_base  = parity_same_q;
			chan_d    = held_channel_q;
			ped_d     = held_pedestal_q;
			sflag_d   = sigma_flag_q;
		end

		// Q12.4 distance, exact
		s16      = {sample_s1, 4'b0000};
		ped_gap  = (s16 >= ped_d) ? (s16 - ped_d) : (ped_d - s16);
		dist_lim = {ped_distance_q, 4'b0000};
		is_away  = ped_gap > dist_lim;

		bad_cnt_d = bad_base;
		if (sample_s1 == wfncf_pkg::BAD_CODE && bad_base < CNT_MAX) begin
			bad_cnt_d = bad_base + CNT_W'(1);
		end
		away_cnt_d = away_base;
		if (is_away && away_base < CNT_MAX) begin
			away_cnt_d = away_base + CNT_W'(1);
		end
		par_d = par_base & (sample_s1[0] == fp_d);

		r_bad_codes = CMP_W'(bad_cnt_d) > CMP_W'(bad_code_cut_q);
		r_away      = CMP_W'(away_cnt_d) > CMP_W'(away_cut_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_parity_q  <= 1'b0;
			bad_cnt_q       <= '0;
			away_cnt_q      <= '0;
			parity_same_q   <= 1'b1;
			held_channel_q  <= '0;
			held_pedestal_q <= '0;
			sigma_flag_q    <= 1'b0;
		end else if (advance_s1) begin
			first_parity_q  <= fp_d;
			bad_cnt_q       <= bad_cnt_d;
			away_cnt_q      <= away_cnt_d;
			parity_same_q   <= par_d;
			held_channel_q  <= chan_d;
			held_pedestal_q <= ped_d;
			sigma_flag_q    <= sflag_d;
		end
	end

	// result register
	logic                            load_out;
	logic [wfncf_pkg::CHANNEL_W-1:0] channel_out_q;
	logic                            sigma_high_q;
	logic                            bad_codes_q;
	logic                            parity_q;
	logic                            away_q;

	assign load_out = advance_s1 & last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			channel_out_q <= chan_d;
			sigma_high_q  <= sflag_d;
			bad_codes_q   <= r_bad_codes;
			parity_q      <= par_d;
			away_q        <= r_away;
		end
	end

	assign out_valid      = out_valid_q;
	assign channel_out    = channel_out_q;
	assign sigma_high     = sigma_high_q;
	assign bad_codes_high = bad_codes_q;
	assign same_parity    = parity_q;
	assign away_high      = away_q;
	assign bad            = sigma_high_q | bad_codes_q | parity_q | away_q;

endmodule
